// ===== hdl/spdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdd_pkg
// Shared types and constants of the sound pulse direction detector.
// ----------------------------------------------------------------------------
package spdd_pkg;

   localparam int TIME_W      = 32;
   localparam int SUM_W       = 39;
   localparam int CNT_W       = 7;
   localparam int CAPACITY    = 100;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_W      = $clog2(SUM_W + 1);

   localparam logic [TIME_W-1:0] THRESH_RESET = TIME_W'(1000);

   // request type codes as they arrive on the input channel
   localparam logic [1:0] REQ_EDGE   = 2'd0;
   localparam logic [1:0] REQ_CLOSE  = 2'd1;
   localparam logic [1:0] REQ_DECIDE = 2'd2;

   localparam logic [1:0] WIN_NONE  = 2'd0;
   localparam logic [1:0] WIN_LEFT  = 2'd1;
   localparam logic [1:0] WIN_RIGHT = 2'd2;

   typedef enum logic [1:0] {
      OP_EDGE,
      OP_CLOSE,
      OP_DECIDE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                channel;
      logic                pin_left;
      logic                pin_right;
      logic [TIME_W-1:0]   time_us;
   } entry_type;

   typedef struct packed {
      logic                start;
      logic [SUM_W-1:0]    dividend;
      logic [CNT_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [SUM_W-1:0]    quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_OPEN,
      S_START,
      S_WAIT
   } state_type;

endpackage

// ===== hdl/spdd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdd_front
// Accepts request items, decodes the request type and queues them for the
// back end.
// ----------------------------------------------------------------------------
module spdd_front
   import spdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic                req_channel,
   input  logic                req_pin_left,
   input  logic                req_pin_right,
   input  logic [TIME_W-1:0]   req_time_us,
   output logic                q_valid,
   output entry_type           q_entry,
   input  logic                q_pop
);

   entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   entry_type          new_entry;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      new_entry.channel   = req_channel;
      new_entry.pin_left  = req_pin_left;
      new_entry.pin_right = req_pin_right;
      new_entry.time_us   = req_time_us;
      case (req_type)
         REQ_EDGE:   new_entry.op = OP_EDGE;
         REQ_CLOSE:  new_entry.op = OP_CLOSE;
         REQ_DECIDE: new_entry.op = OP_DECIDE;
         default:    new_entry.op = OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== hdl/spdd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdd_div
// Restoring bit-serial divider: interval sum over interval count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module spdd_div
   import spdd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  div_req,
   output div_rsp_type  div_rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   dsr_ff, dsr_in;
   logic [CNT_W:0]     trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when the divisor fits
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? CNT_W'(trial - {1'b0, dsr_ff}) : trial[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hdl/spdd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdd_back
// Executes queued items: pin edges, window closes, direction decisions and
// unused request types; holds the channel state, the threshold and the result register.
// ----------------------------------------------------------------------------
module spdd_back
   import spdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_loud_threshold_us,
   input  logic                q_valid,
   input  entry_type           q_entry,
   output logic                q_pop,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_led_left,
   output logic                rsp_led_right,
   output logic [TIME_W-1:0]   rsp_window_average_us,
   output logic [1:0]          rsp_winner,
   output logic [TIME_W-1:0]   rsp_delay_us
);

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  thresh_ff, thresh_in;
   logic [TIME_W-1:0]  start_ff [2];
   logic [TIME_W-1:0]  start_in [2];
   logic [TIME_W-1:0]  stop_ff  [2];
   logic [TIME_W-1:0]  stop_in  [2];
   logic [SUM_W-1:0]   sum_ff   [2];
   logic [SUM_W-1:0]   sum_in   [2];
   logic [CNT_W-1:0]   cnt_ff   [2];
   logic [CNT_W-1:0]   cnt_in   [2];
   logic [TIME_W-1:0]  avg_ff   [2];
   logic [TIME_W-1:0]  avg_in   [2];
   logic [1:0]         led_ff, led_in;
   logic               ch_ff, ch_in;
   logic [TIME_W-1:0]  now_ff, now_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_led_ff, rsp_led_in;
   logic [TIME_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [1:0]         rsp_win_ff, rsp_win_in;
   logic [TIME_W-1:0]  rsp_delay_ff, rsp_delay_in;

   logic               out_free;
   logic               pin;
   logic [TIME_W-1:0]  len;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      thresh_in    = csr_wr_en ? csr_loud_threshold_us : thresh_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      avg_in       = avg_ff;
      led_in       = led_ff;
      ch_in        = ch_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_led_in   = rsp_led_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_delay_in = rsp_delay_ff;
      q_pop        = 1'b0;
      div_req      = '0;
      pin          = 1'b0;
      len          = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_entry.op)
                  OP_EDGE: begin
                     for (int i = 0; i < 2; i++) begin
                        pin = (i == 0) ? q_entry.pin_left : q_entry.pin_right;
                        len = q_entry.time_us - start_ff[i];
                        if (!pin) begin
                           start_in[i] = q_entry.time_us;
                           led_in[i]   = 1'b1;
                        end else begin
                           stop_in[i] = q_entry.time_us;
                           led_in[i]  = 1'b0;
                           if (start_ff[i] != '0 && cnt_ff[i] < CNT_W'(CAPACITY)) begin
                              sum_in[i] = sum_ff[i] + SUM_W'(len);
                              cnt_in[i] = cnt_ff[i] + 1'b1;
                           end
                        end
                     end
                     rsp_valid_in = 1'b1;
                     rsp_led_in   = led_in;
                     rsp_avg_in   = '0;
                     rsp_win_in   = WIN_NONE;
                     rsp_delay_in = '0;
                  end
                  OP_CLOSE: begin
                     ch_in    = q_entry.channel;
                     now_in   = q_entry.time_us;
                     state_in = S_OPEN;
                  end
                  OP_DECIDE: begin
                     for (int i = 0; i < 2; i++) begin
                        start_in[i] = '0;
                        avg_in[i]   = '0;
                        sum_in[i]   = '0;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_led_in   = led_ff;
                     rsp_avg_in   = '0;
                     rsp_win_in   = WIN_NONE;
                     rsp_delay_in = '0;
                     if (avg_ff[0] > thresh_ff || avg_ff[1] > thresh_ff) begin
                        // a tie goes to the right side
                        if (avg_ff[0] > avg_ff[1]) begin
                           rsp_win_in   = WIN_LEFT;
                           rsp_delay_in = avg_ff[0];
                        end else begin
                           rsp_win_in   = WIN_RIGHT;
                           rsp_delay_in = avg_ff[1];
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_led_in   = led_ff;
                     rsp_avg_in   = '0;
                     rsp_win_in   = WIN_NONE;
                     rsp_delay_in = '0;
                  end
               endcase
            end
         end
         S_OPEN: begin
            // record a pulse that is still open at window close
            len = now_ff - start_ff[ch_ff];
            if (stop_ff[ch_ff] < start_ff[ch_ff]) begin
               stop_in[ch_ff] = now_ff;
               if (cnt_ff[ch_ff] < CNT_W'(CAPACITY)) begin
                  sum_in[ch_ff] = sum_ff[ch_ff] + SUM_W'(len);
                  cnt_in[ch_ff] = cnt_ff[ch_ff] + 1'b1;
               end
            end
            state_in = S_START;
         end
         S_START: begin
            if (cnt_ff[ch_ff] != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = sum_ff[ch_ff];
               div_req.divisor  = cnt_ff[ch_ff];
               state_in         = S_WAIT;
            end else begin
               // empty window: keep the previous average
               sum_in[ch_ff] = '0;
               rsp_valid_in  = 1'b1;
               rsp_led_in    = led_ff;
               rsp_avg_in    = avg_ff[ch_ff];
               rsp_win_in    = WIN_NONE;
               rsp_delay_in  = '0;
               state_in      = S_IDLE;
            end
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               avg_in[ch_ff] = div_rsp.quotient[TIME_W-1:0];
               cnt_in[ch_ff] = '0;
               sum_in[ch_ff] = '0;
               rsp_valid_in  = 1'b1;
               rsp_led_in    = led_ff;
               rsp_avg_in    = div_rsp.quotient[TIME_W-1:0];
               rsp_win_in    = WIN_NONE;
               rsp_delay_in  = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thresh_ff    <= THRESH_RESET;
         start_ff     <= '{default: '0};
         stop_ff      <= '{default: '0};
         sum_ff       <= '{default: '0};
         cnt_ff       <= '{default: '0};
         avg_ff       <= '{default: '0};
         led_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         avg_ff       <= avg_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      now_ff       <= now_in;
      rsp_led_ff   <= rsp_led_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_win_ff   <= rsp_win_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_led_left          = rsp_led_ff[0];
   assign rsp_led_right         = rsp_led_ff[1];
   assign rsp_window_average_us = rsp_avg_ff;
   assign rsp_winner            = rsp_win_ff;
   assign rsp_delay_us          = rsp_delay_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !q_pop)
      else $error("queue popped while a window close is in progress");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_WAIT))
      else $error("divider finished outside the wait state");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= CNT_W'(CAPACITY)) && (cnt_ff[1] <= CNT_W'(CAPACITY)))
      else $error("interval count above capacity");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (state_ff == S_WAIT))
      else $error("divider started without entering the wait state");

endmodule

// ===== hdl/sound_pulse_direction_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_pulse_direction_detector
// Two-channel sound pulse timer that averages pulse lengths per window and
// reports the louder side.
// ----------------------------------------------------------------------------
// Pin edge, decide and unused request items are each handled in S_IDLE of the
// back end once they reach the head of the two-entry input queue, so such items
// stream at one per cycle while the result register is not held by rsp_stall.
// A window close steps through taking it from the queue, recording a still-open
// pulse, launching the division, the bit-serial divider that forms the interval
// average, and writing the result register. A close of an empty window skips
// the divider. The input queue keeps accepting items while a close is being
// worked on until it holds two. The back end takes no new item while a finished
// result still waits on rsp_stall.
// Threshold writes on the csr_ port take effect at the next clock edge.
// ----------------------------------------------------------------------------
module sound_pulse_direction_detector
   import spdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_loud_threshold_us,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic                req_channel,
   input  logic                req_pin_left,
   input  logic                req_pin_right,
   input  logic [TIME_W-1:0]   req_time_us,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_led_left,
   output logic                rsp_led_right,
   output logic [TIME_W-1:0]   rsp_window_average_us,
   output logic [1:0]          rsp_winner,
   output logic [TIME_W-1:0]   rsp_delay_us
);

   logic         q_valid;
   entry_type    q_entry;
   logic         q_pop;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   spdd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_channel   (req_channel),
      .req_pin_left  (req_pin_left),
      .req_pin_right (req_pin_right),
      .req_time_us   (req_time_us),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   spdd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   spdd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_loud_threshold_us (csr_loud_threshold_us),
      .q_valid               (q_valid),
      .q_entry               (q_entry),
      .q_pop                 (q_pop),
      .div_req               (div_req),
      .div_rsp               (div_rsp),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_led_left          (rsp_led_left),
      .rsp_led_right         (rsp_led_right),
      .rsp_window_average_us (rsp_window_average_us),
      .rsp_winner            (rsp_winner),
      .rsp_delay_us          (rsp_delay_us)
   );

endmodule
